// ===== rtl/spdg_pkg.sv =====
`timescale 1ns / 1ps
package spdg_pkg;

	localparam int MaxV = 16;
	localparam int VW   = $clog2(MaxV);
	localparam int CW   = 5;
	localparam int LW   = 31;
	localparam int DW   = 36;
	localparam int AW   = 2 * VW;
	localparam int SW   = 2;

	localparam logic [DW-1:0] IntMax = DW'(36'h07FFFFFFF);
	localparam logic [DW-1:0] IntLim = DW'(36'h080000000);

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_RUN   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [1:0] KIND_DIST   = 2'd0;
	localparam logic [1:0] KIND_PATH   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOPATH = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;
	localparam logic [1:0] ST_BAD    = 2'd3;

	typedef enum logic [1:0] {
		MODE_SEL   = 2'd0,
		MODE_RELAX = 2'd1,
		MODE_WIDE  = 2'd2,
		MODE_PRED  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]    func;
		logic [CW-1:0] vertex_a;
		logic [CW-1:0] vertex_b;
		logic [LW-1:0] edge_length;
	} item_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [CW-1:0] vertex_number;
		logic [DW-1:0] distance;
		logic          reachable;
		logic          above_int_max;
		logic [1:0]    status;
		logic          last;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       clear;
		logic       add_fwd;
		logic       add_rev;
		logic       run_init;
		logic       scan_start;
		mode_t      mode;
		logic       sel_commit;
		logic       settle;
		logic       dout_clr;
		logic       dout_adv;
		logic       load_fin;
		logic       pred_commit;
		logic       out_load;
		logic [1:0] out_kind;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic scan_done;
		logic found;
		logic fin_known;
		logic ovf;
		logic path_end;
		logic dout_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/spdg_ctrl.sv =====
`timescale 1ns / 1ps
module spdg_ctrl import spdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_func,
	input  sts_t       sts,
	output logic       item_stall,
	output cmd_t       cmd
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_ADD1  = 13'b0000000000010,
		S_ADD2  = 13'b0000000000100,
		S_INIT  = 13'b0000000001000,
		S_SEL   = 13'b0000000010000,
		S_RELAX = 13'b0000000100000,
		S_DOUT  = 13'b0000001000000,
		S_DEND  = 13'b0000010000000,
		S_WIDE  = 13'b0000100000000,
		S_PEMIT = 13'b0001000000000,
		S_PCHK  = 13'b0010000000000,
		S_PRED  = 13'b0100000000000,
		S_STAT  = 13'b1000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] st_q, st_d;
	logic       accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.mode = MODE_SEL;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (func_t'(item_func))
						FUNC_ADD: begin
							if (sts.bad) begin
								st_d    = ST_BAD;
								state_d = S_STAT;
							end else begin
								state_d = S_ADD1;
							end
						end
						FUNC_RUN: begin
							if (sts.bad) begin
								st_d    = ST_BAD;
								state_d = S_STAT;
							end else begin
								state_d = S_INIT;
							end
						end
						FUNC_CLEAR: cmd.clear = 1'b1;
						FUNC_NONE: ;
					endcase
				end
			end
			S_ADD1: begin
				cmd.add_fwd = 1'b1;
				state_d     = S_ADD2;
			end
			S_ADD2: begin
				cmd.add_rev = 1'b1;
				state_d     = S_IDLE;
			end
			S_INIT: begin
				cmd.run_init   = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.mode       = MODE_SEL;
				state_d        = S_SEL;
			end
			S_SEL: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						cmd.sel_commit = 1'b1;
						cmd.scan_start = 1'b1;
						cmd.mode       = MODE_RELAX;
						state_d        = S_RELAX;
					end else begin
						cmd.dout_clr = 1'b1;
						state_d      = S_DOUT;
					end
				end
			end
			S_RELAX: begin
				if (sts.scan_done) begin
					cmd.settle     = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.mode       = MODE_SEL;
					state_d        = S_SEL;
				end
			end
			S_DOUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DIST;
					if (sts.dout_last) begin
						state_d = S_DEND;
					end else begin
						cmd.dout_adv = 1'b1;
					end
				end
			end
			S_DEND: begin
				if (!sts.fin_known) begin
					st_d    = ST_NOPATH;
					state_d = S_STAT;
				end else begin
					cmd.load_fin   = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.mode       = MODE_WIDE;
					state_d        = S_WIDE;
				end
			end
			S_WIDE: begin
				if (sts.scan_done) begin
					if (sts.ovf) begin
						st_d    = ST_OVF;
						state_d = S_STAT;
					end else begin
						state_d = S_PEMIT;
					end
				end
			end
			S_PEMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_PATH;
					state_d      = S_PCHK;
				end
			end
			S_PCHK: begin
				if (sts.path_end) begin
					st_d    = ST_OK;
					state_d = S_STAT;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.mode       = MODE_PRED;
					state_d        = S_PRED;
				end
			end
			S_PRED: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						cmd.pred_commit = 1'b1;
						state_d         = S_PEMIT;
					end else begin
						st_d    = ST_OK;
						state_d = S_STAT;
					end
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = KIND_STATUS;
					cmd.out_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

// ===== rtl/spdg_dp.sv =====
`timescale 1ns / 1ps
module spdg_dp import spdg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  item_t         item,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_data,
	input  logic          result_stall,
	output sts_t          sts,
	output logic          result_valid,
	output result_t       result
);

	logic [CW-1:0] vc_q, n;
	logic [VW-1:0] nm1;
	logic [VW-1:0] s_q, f_q, m_q, cur_q, pick_q, j_q, row;
	logic [LW-1:0] len_q;
	logic [DW-1:0] dm_q, pickd_q, fin_d_q;
	logic [CW-1:0] steps_q;
	logic          found_q;
	logic [1:0]    wide_q;

	logic [LW-1:0]      adj_mem [MaxV*MaxV];
	logic [MaxV*MaxV-1:0] adj_vld_q;
	logic [LW-1:0]      rd_s1;
	logic               rd_vld_s1;
	logic [LW-1:0]      l_s1;
	logic               wr_en;
	logic [AW-1:0]      wr_addr, rd_addr;

	mode_t         mode_q;
	logic          issue_q, v_s1, last_s1, done_q;
	logic [VW-1:0] cnt_q, idx_s1;

	logic [DW-1:0]   dist_q [MaxV];
	logic [MaxV-1:0] known_q, settled_q;
	logic [VW-1:0]   rd_idx;
	logic [DW-1:0]   d_rd, cand, pd_sum;
	logic            kn_rd;

	logic    out_free;
	result_t res_d;

	always_comb begin
		priority if (vc_q == '0) n = CW'(1);
		else if (vc_q > CW'(MaxV)) n = CW'(MaxV);
		else n = vc_q;
	end
	assign nm1 = VW'(n - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= CW'(16);
		end else if (cfg_we) begin
			vc_q <= cfg_data;
		end
	end

	assign sts.bad = (item.vertex_a == '0) || (item.vertex_a > n) ||
	                 (item.vertex_b == '0) || (item.vertex_b > n);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q   <= VW'(item.vertex_a - CW'(1));
			f_q   <= VW'(item.vertex_b - CW'(1));
			len_q <= item.edge_length;
		end
	end

	// adjacency store: one write port, one registered read port
	assign wr_en   = cmd.add_fwd || cmd.add_rev;
	assign wr_addr = cmd.add_fwd ? {s_q, f_q} : {f_q, s_q};

	always_comb begin
		unique case (mode_q)
			MODE_SEL:   row = '0;
			MODE_RELAX: row = m_q;
			MODE_WIDE:  row = f_q;
			MODE_PRED:  row = cur_q;
		endcase
	end
	assign rd_addr = {row, cnt_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			adj_mem[wr_addr] <= len_q;
		end
		rd_s1 <= adj_mem[rd_addr];
	end

	// never-written entries read as no edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				adj_vld_q <= '0;
			end else if (wr_en) begin
				adj_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= adj_vld_q[rd_addr];
		end
	end
	assign l_s1 = rd_vld_s1 ? rd_s1 : '0;

	// row scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEL;
			issue_q <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				mode_q  <= cmd.mode;
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else if (issue_q) begin
				cnt_q <= cnt_q + VW'(1);
				if (cnt_q == nm1) issue_q <= 1'b0;
			end
			v_s1    <= issue_q;
			idx_s1  <= cnt_q;
			last_s1 <= issue_q && (cnt_q == nm1);
			done_q  <= v_s1 && last_s1;
		end
	end

	assign rd_idx = v_s1 ? idx_s1 : j_q;
	assign d_rd   = dist_q[rd_idx];
	assign kn_rd  = known_q[rd_idx];
	assign cand   = dm_q + DW'(l_s1);
	assign pd_sum = d_rd + DW'(l_s1);

	always_ff @(posedge clk) begin
		if (cmd.run_init) begin
			dist_q[s_q] <= '0;
		end else if (v_s1 && mode_q == MODE_RELAX && !settled_q[idx_s1] && l_s1 != '0 &&
		             (!kn_rd || d_rd > cand)) begin
			dist_q[idx_s1] <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q   <= '0;
			settled_q <= '0;
			found_q   <= 1'b0;
			pick_q    <= '0;
			wide_q    <= '0;
		end else begin
			if (cmd.run_init) begin
				known_q        <= '0;
				known_q[s_q]   <= 1'b1;
				settled_q      <= '0;
			end else begin
				if (cmd.settle) settled_q[m_q] <= 1'b1;
				if (v_s1 && mode_q == MODE_RELAX && !settled_q[idx_s1] && l_s1 != '0 &&
				    (!kn_rd || d_rd > cand)) begin
					known_q[idx_s1] <= 1'b1;
				end
			end
			if (cmd.scan_start) begin
				found_q <= 1'b0;
				wide_q  <= '0;
			end else if (v_s1) begin
				unique case (mode_q)
					MODE_SEL: begin
						if (kn_rd && !settled_q[idx_s1] && (!found_q || d_rd < pickd_q)) begin
							found_q <= 1'b1;
							pick_q  <= idx_s1;
						end
					end
					MODE_RELAX: ;
					MODE_WIDE: begin
						if (l_s1 != '0 && cand >= IntLim && wide_q != 2'd2) begin
							wide_q <= wide_q + 2'd1;
						end
					end
					MODE_PRED: begin
						if (!found_q && l_s1 != '0 && kn_rd && dm_q == pd_sum) begin
							found_q <= 1'b1;
							pick_q  <= idx_s1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !cmd.scan_start) begin
			if ((mode_q == MODE_SEL && kn_rd && !settled_q[idx_s1] &&
			     (!found_q || d_rd < pickd_q)) ||
			    (mode_q == MODE_PRED && !found_q && l_s1 != '0 && kn_rd && dm_q == pd_sum)) begin
				pickd_q <= d_rd;
			end
		end
	end

	// search registers: selected vertex, path cursor, distance out counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q     <= '0;
			cur_q   <= '0;
			steps_q <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.sel_commit) m_q <= pick_q;
			if (cmd.dout_clr) j_q <= '0;
			else if (cmd.dout_adv) j_q <= j_q + VW'(1);
			if (cmd.load_fin) begin
				cur_q   <= f_q;
				steps_q <= '0;
			end else if (cmd.pred_commit) begin
				cur_q   <= pick_q;
				steps_q <= steps_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_commit) dm_q <= pickd_q;
		else if (cmd.load_fin) dm_q <= fin_d_q;
		else if (cmd.pred_commit) dm_q <= pickd_q;
		if (cmd.out_load && cmd.out_kind == KIND_DIST && j_q == f_q) fin_d_q <= d_rd;
	end

	assign sts.scan_done = done_q;
	assign sts.found     = found_q;
	assign sts.fin_known = known_q[f_q];
	assign sts.ovf       = (dm_q > IntMax) && (wide_q == 2'd2);
	assign sts.path_end  = (cur_q == s_q) || (steps_q >= n);
	assign sts.dout_last = (j_q == nm1);
	assign sts.out_free  = out_free;

	// output register
	assign out_free = !result_valid || !result_stall;

	always_comb begin
		res_d = '0;
		unique case (cmd.out_kind)
			KIND_DIST: begin
				res_d.kind          = KIND_DIST;
				res_d.vertex_number = CW'({1'b0, j_q}) + CW'(1);
				res_d.distance      = kn_rd ? d_rd : '0;
				res_d.reachable     = kn_rd;
				res_d.above_int_max = kn_rd && (d_rd > IntMax);
			end
			KIND_PATH: begin
				res_d.kind          = KIND_PATH;
				res_d.vertex_number = CW'({1'b0, cur_q}) + CW'(1);
				res_d.distance      = dm_q;
				res_d.reachable     = 1'b1;
				res_d.above_int_max = dm_q > IntMax;
			end
			default: begin
				res_d.kind   = KIND_STATUS;
				res_d.status = cmd.out_status;
				res_d.last   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) result <= res_d;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free) else $error("result overwritten while held");
	a_settle_known: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.settle |-> known_q[m_q] && !settled_q[m_q]) else $error("settling bad vertex");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !issue_q) else $error("scan done while issuing");
	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_init |=> known_q[s_q] && settled_q == '0) else $error("run init failed");
	a_wide: assert property (@(posedge clk) disable iff (!arst_n)
		wide_q != 2'd3) else $error("wide count overrun");

endmodule

// ===== rtl/shortest_path_dense_graph.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// item      in         item_valid/item_stall item_t (func, vertex_a, vertex_b, edge_length)
// result    out        result_valid/result_stall result_t (kind .. last)
// config    in         cfg_we                cfg_data = vertex_count
//
// Add edge: two writes (forward, reverse) through the one adjacency write port; clear acts on accept.
// Run: every settled vertex costs a select scan and a relax scan through the adjacency read
// port, and one more select scan ends the search; then come n distance results and, per path
// step, an emit, a check and a predecessor scan.
// Reset clears every edge at once and sets vertex_count to 16.
// A stalled result holds the block when it next has a result to load; no item is taken during a run.
module shortest_path_dense_graph import spdg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  item_t         item,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	spdg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	spdg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
